// ===== rtl/core/k_weighted_mean_square_core_defines.svh =====
// Assertion macros shared by the K-weighting core.
`ifndef K_WEIGHTED_MEAN_SQUARE_CORE_DEFINES_SVH
`define K_WEIGHTED_MEAN_SQUARE_CORE_DEFINES_SVH
`define KW_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define KW_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/kwms_pkg.sv =====
// Types and constants for the K-weighting core.
`timescale 1ns / 1ps
`default_nettype none
package kwms_pkg;
  localparam int REG_COUNT = 8;
  localparam logic [2:0] REG_HP_NORM = 3'd0;
  localparam logic [2:0] REG_HP_A1 = 3'd1;
  localparam logic [2:0] REG_HP_A2 = 3'd2;
  localparam logic [2:0] REG_SH_B0 = 3'd3;
  localparam logic [2:0] REG_SH_B1 = 3'd4;
  localparam logic [2:0] REG_SH_B2 = 3'd5;
  localparam logic [2:0] REG_SH_A1 = 3'd6;
  localparam logic [2:0] REG_SH_A2 = 3'd7;
  localparam logic [31:0] RST_HP_NORM = 32'sd534210180;
  localparam logic [31:0] RST_HP_A1 = -32'sd1068413917;
  localparam logic [31:0] RST_HP_A2 = 32'sd531556427;
  localparam logic [31:0] RST_SH_B0 = 32'sd824163959;
  localparam logic [31:0] RST_SH_B1 = -32'sd1445093286;
  localparam logic [31:0] RST_SH_B2 = 32'sd643382342;
  localparam logic [31:0] RST_SH_A1 = -32'sd907665639;
  localparam logic [31:0] RST_SH_A2 = 32'sd393247742;
  typedef enum logic [2:0] {
    ST_IDLE, ST_MAC, ST_SQ, ST_ACC, ST_DIV, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ===== rtl/core/k_weighted_mean_square_core.sv =====
// K-weighting filter cascade with block mean-square output.
// Each in-range item passes through the transfer, ten multiply-accumulate steps on one
// shared 33x33 multiplier, one squaring step and one accumulate step. A block-end item
// then runs a one-bit-per-cycle restoring divider over the 64-bit quotient and loads the
// result when the output is free; a zero count skips the divider. Synchronous
// active-high reset restores the coefficients and clears state.
`timescale 1ns / 1ps
`default_nettype none
`include "k_weighted_mean_square_core_defines.svh"
module k_weighted_mean_square_core
  import kwms_pkg::*;
#(
  parameter int CHANNELS = 2,
  parameter int MAX_BLOCK_SAMPLES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid_in,
  output logic             stall_in,
  input  wire logic        channel,
  input  wire logic [23:0] sample,
  input  wire logic        block_end,
  output logic             valid_out,
  input  wire logic        stall_out,
  output logic [47:0]      mean_square,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam int CW = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int HD = 2;

  state_t state, state_next;
  logic [31:0] regs [REG_COUNT];
  logic signed [31:0] xi [HD][2];
  logic signed [31:0] yo [HD][2];
  logic signed [31:0] zo [HD][2];
  logic [63:0] acc;
  logic [CW-1:0] cnt;
  logic ch;
  logic chok;
  logic chok_in;
  logic cnt_up;
  logic out_free;
  logic endf;
  logic signed [31:0] x;
  logic signed [31:0] y1;
  logic signed [31:0] y2;
  logic [3:0] step;
  logic signed [72:0] sum;
  logic signed [72:0] term;
  logic signed [72:0] sum_next;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod;
  logic [63:0] sq;
  logic [63:0] quo;
  logic [64:0] rem;
  logic [6:0] dcnt;
  logic [64:0] rtrial;

  function automatic logic signed [31:0] sat_q(input logic signed [72:0] s);
    logic signed [48:0] t;
    t = s[72:24];
    if (t > 49'sd2147483647) return 32'sh7fffffff;
    if (t < -49'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      4'd0: begin ma = {regs[REG_HP_NORM][31], regs[REG_HP_NORM]}; mb = {x[31], x}; end
      4'd1: begin ma = {regs[REG_HP_NORM], 1'b0}; mb = -{xi[ch][0][31], xi[ch][0]}; end
      4'd2: begin ma = {regs[REG_HP_NORM][31], regs[REG_HP_NORM]}; mb = {xi[ch][1][31], xi[ch][1]}; end
      4'd3: begin ma = {regs[REG_HP_A1][31], regs[REG_HP_A1]}; mb = {yo[ch][0][31], yo[ch][0]}; end
      4'd4: begin ma = {regs[REG_HP_A2][31], regs[REG_HP_A2]}; mb = {yo[ch][1][31], yo[ch][1]}; end
      4'd5: begin ma = {regs[REG_SH_B0][31], regs[REG_SH_B0]}; mb = {y1[31], y1}; end
      4'd6: begin ma = {regs[REG_SH_B1][31], regs[REG_SH_B1]}; mb = {yo[ch][0][31], yo[ch][0]}; end
      4'd7: begin ma = {regs[REG_SH_B2][31], regs[REG_SH_B2]}; mb = {yo[ch][1][31], yo[ch][1]}; end
      4'd8: begin ma = {regs[REG_SH_A1][31], regs[REG_SH_A1]}; mb = {zo[ch][0][31], zo[ch][0]}; end
      4'd9: begin ma = {regs[REG_SH_A2][31], regs[REG_SH_A2]}; mb = {zo[ch][1][31], zo[ch][1]}; end
      default: begin ma = {y2[31], y2}; mb = {y2[31], y2}; end
    endcase
  end

  assign prod = ma * mb;
  assign rtrial = {rem[63:0], acc[63]} - {{(65-CW){1'b0}}, cnt};

  // Feedback terms are floored before they are subtracted.
  always_comb begin
    term = (step <= 4'd2) ? 73'(prod >>> 4) : 73'(prod >>> 5);
    case (step) inside
      4'd3, 4'd4, 4'd8, 4'd9: sum_next = sum - term;
      default: sum_next = sum + term;
    endcase
  end

  assign chok = (32'(ch) < CHANNELS);
  assign chok_in = (32'(channel) < CHANNELS);
  assign cnt_up = chok && !ch && (32'(cnt) < MAX_BLOCK_SAMPLES);
  assign out_free = !valid_out || !stall_out;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (valid_in && !stall_in) state_next = chok_in ? ST_MAC : ST_ACC;
      ST_MAC: if (step == 4'd9) state_next = ST_SQ;
      ST_SQ: state_next = ST_ACC;
      ST_ACC: if (endf) state_next = (cnt == '0 && !cnt_up) ? ST_OUT : ST_DIV;
              else state_next = ST_IDLE;
      ST_DIV: if (dcnt == 7'd63) state_next = ST_OUT;
      ST_OUT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stall_in = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid_out <= 1'b0;
      regs[0] <= RST_HP_NORM; regs[1] <= RST_HP_A1; regs[2] <= RST_HP_A2;
      regs[3] <= RST_SH_B0; regs[4] <= RST_SH_B1; regs[5] <= RST_SH_B2;
      regs[6] <= RST_SH_A1; regs[7] <= RST_SH_A2;
      for (int c = 0; c < HD; c++) begin
        xi[c][0] <= '0; xi[c][1] <= '0; yo[c][0] <= '0; yo[c][1] <= '0;
        zo[c][0] <= '0; zo[c][1] <= '0;
      end
      acc <= '0;
      cnt <= '0;
      step <= '0;
    end else begin
      state <= state_next;
      if (valid_out && !stall_out) valid_out <= 1'b0;
      if (cfg_we) begin
        regs[cfg_index] <= cfg_data;
        for (int c = 0; c < HD; c++) begin
          xi[c][0] <= '0; xi[c][1] <= '0; yo[c][0] <= '0; yo[c][1] <= '0;
          zo[c][0] <= '0; zo[c][1] <= '0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          ch <= channel;
          x <= {{8{sample[23]}}, sample};
          endf <= block_end;
          step <= '0;
          sum <= '0;
        end
        ST_MAC: begin
          step <= step + 4'd1;
          if (step == 4'd4) begin
            y1 <= sat_q(sum_next);
            sum <= '0;
          end else if (step == 4'd9) begin
            y2 <= sat_q(sum_next);
          end else begin
            sum <= sum_next;
          end
        end
        ST_SQ: begin
          sq <= prod[63:0];
          xi[ch][1] <= xi[ch][0]; xi[ch][0] <= x;
          yo[ch][1] <= yo[ch][0]; yo[ch][0] <= y1;
          zo[ch][1] <= zo[ch][0]; zo[ch][0] <= y2;
        end
        ST_ACC: begin
          if (chok) begin
            acc <= ({1'b0, acc} + {1'b0, sq} > 65'h0_ffff_ffff_ffff_ffff) ?
                   64'hffff_ffff_ffff_ffff : acc + sq;
          end
          if (cnt_up) cnt <= cnt + 1'b1;
          rem <= '0;
          quo <= '0;
          dcnt <= '0;
        end
        ST_DIV: begin
          dcnt <= dcnt + 7'd1;
          acc <= {acc[62:0], 1'b0};
          if (!rtrial[64]) begin
            rem <= rtrial;
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= {rem[63:0], acc[63]};
            quo <= {quo[62:0], 1'b0};
          end
        end
        ST_OUT: begin
          if (out_free) begin
            valid_out <= 1'b1;
            mean_square <= (cnt == '0) ? 48'd0 :
                           (quo[63:52] != '0) ? 48'hffff_ffff_ffff : quo[51:4];
            acc <= '0;
            cnt <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `KW_ASSERT_IMPL(a_busy_stall, clk, rst, state != ST_IDLE, stall_in)
  `KW_ASSERT_NEXT(a_out_hold, clk, rst, valid_out && stall_out, valid_out && $stable(mean_square))
  `KW_ASSERT_NEXT(a_out_src, clk, rst, state == ST_OUT && out_free, valid_out)
endmodule
`default_nettype wire
